// ----- design/dte_pkg.sv -----
package dte_pkg;

	localparam int EST_FRAC_BITS_DEF     = 16;
	localparam int LOG_FRAC_BITS_DEF     = 16;
	localparam int SUM_TOLERANCE_LSB_DEF = 2;

	localparam int FREQ_W  = 32;
	localparam int COUNT_W = 32;
	localparam int ALPHA_W = 16;
	localparam int NUM_W   = 64;
	localparam int DEN_W   = 66;
	localparam int FRAC_W  = 32;
	localparam int LANES   = 3;

	// ln2 in Q0.24
	localparam logic [23:0] LN2_Q24 = 24'd11629080;

	typedef enum logic [1:0] {
		SRC_MATCH   = 2'd0,
		SRC_INSERT  = 2'd1,
		SRC_DELETE  = 2'd2,
		SRC_INVALID = 2'd3
	} src_state_t;

	typedef enum logic [1:0] {
		STAT_OK       = 2'd0,
		STAT_ZERO_DEN = 2'd1,
		STAT_SUM_TOL  = 2'd2,
		STAT_INVALID  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_EFF_MATCH  = 2'd0,
		REG_EFF_INSERT = 2'd1,
		REG_EFF_DELETE = 2'd2,
		REG_LOG_FLOOR  = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic invalid;
		logic zero_den;
	} item_flags_t;

	// Dirichlet alphas, Q0.16, per source state and destination lane
	function automatic logic [ALPHA_W-1:0] alpha_of(input logic [1:0] st, input int unsigned k);
		logic [ALPHA_W-1:0] a;
		a = '0;
		unique case (st)
			SRC_MATCH:  a = (k == 0) ? 16'd52029 : 16'd1534;
			SRC_INSERT: a = (k == 0) ? 16'd10165 : ((k == 1) ? 16'd30494 : 16'd0);
			SRC_DELETE: a = (k == 0) ? 16'd19667 : ((k == 2) ? 16'd58996 : 16'd0);
			default:    a = '0;
		endcase
		return a;
	endfunction

endpackage

// ----- design/dte_if.sv -----
interface dte_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  source_state;
	logic [31:0] freq_to_match;
	logic [31:0] freq_to_insert;
	logic [31:0] freq_to_delete;
	modport source (output valid, source_state, freq_to_match, freq_to_insert, freq_to_delete,
		input ready);
	modport sink (input valid, source_state, freq_to_match, freq_to_insert, freq_to_delete,
		output ready);
endinterface

interface dte_out_if #(parameter int EW = 16, parameter int LW = 16);
	logic                valid;
	logic                ready;
	logic [EW:0]         prob_to_match;
	logic [EW:0]         prob_to_insert;
	logic [EW:0]         prob_to_delete;
	logic signed [LW+8:0] logp_to_match;
	logic signed [LW+8:0] logp_to_insert;
	logic signed [LW+8:0] logp_to_delete;
	logic [1:0]          status;
	modport source (output valid, prob_to_match, prob_to_insert, prob_to_delete,
		logp_to_match, logp_to_insert, logp_to_delete, status, input ready);
	modport sink (input valid, prob_to_match, prob_to_insert, prob_to_delete,
		logp_to_match, logp_to_insert, logp_to_delete, status, output ready);
endinterface

interface dte_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/dte_div_lane.sv -----
module dte_div_lane #(
	parameter int EST_FRAC_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic [dte_pkg::NUM_W-1:0]     num,
	input  logic [dte_pkg::DEN_W-1:0]     den,
	output logic [EST_FRAC_BITS:0]        est
);
	import dte_pkg::*;

	localparam int DS = EST_FRAC_BITS + 2;
	localparam int RW = DEN_W + 1;

	logic [RW-1:0]    r_q [DS-1];
	logic [DEN_W-1:0] d_q [DS-1];
	logic [DS-1:0]    q_q [DS];
	logic [DS:0]      q_rnd;

	// one restoring quotient bit per stage
	genvar s;
	generate
		for (s = 0; s < DS; s++) begin : g_st
			logic [RW-1:0]    r_in;
			logic [RW-1:0]    r_sub;
			logic [DEN_W-1:0] d_in;
			logic [DS-1:0]    q_in;
			logic             ge;
			if (s == 0) begin : g_first
				assign r_in = {{(RW-NUM_W){1'b0}}, num};
				assign d_in = den;
				assign q_in = '0;
			end else begin : g_next
				assign r_in = r_q[s-1];
				assign d_in = d_q[s-1];
				assign q_in = q_q[s-1];
			end
			assign ge    = r_in >= {1'b0, d_in};
			assign r_sub = ge ? r_in - {1'b0, d_in} : r_in;
			always_ff @(posedge clk) begin
				if (en) begin
					q_q[s] <= {q_in[DS-2:0], ge};
				end
			end
			if (s < DS - 1) begin : g_rem
				always_ff @(posedge clk) begin
					if (en) begin
						r_q[s] <= {r_sub[RW-2:0], 1'b0};
						d_q[s] <= d_in;
					end
				end
			end
		end
	endgenerate

	// round to nearest, ties up
	assign q_rnd = {1'b0, q_q[DS-1]} + {{DS{1'b0}}, 1'b1};
	assign est   = q_rnd[EST_FRAC_BITS+1:1];
endmodule

// ----- design/dte_log_lane.sv -----
module dte_log_lane #(
	parameter int EST_FRAC_BITS = 16,
	parameter int LOG_FRAC_BITS = 16
) (
	input  logic                             clk,
	input  logic                             en,
	input  logic [EST_FRAC_BITS:0]           x,
	input  logic signed [LOG_FRAC_BITS+8:0]  log_floor,
	output logic [EST_FRAC_BITS:0]           x_out,
	output logic signed [LOG_FRAC_BITS+8:0]  logp
);
	import dte_pkg::*;

	localparam int XW  = EST_FRAC_BITS + 1;
	localparam int LW  = LOG_FRAC_BITS + 9;
	localparam int NSQ = FRAC_W;
	localparam int UW  = 37;
	localparam int PW  = UW + 24;

	// normalize stage
	logic [4:0]  p_c;
	logic [4:0]  sh_c;
	logic [30:0] m_c;
	logic [30:0] m_n;
	logic [4:0]  p_n;
	logic [XW-1:0] x_n;

	always_comb begin
		p_c = '0;
		for (int b = 0; b < XW; b++) begin
			if (x[b]) p_c = 5'(b);
		end
		sh_c = 5'd30 - p_c;
		m_c  = 31'(x) << sh_c;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_n <= m_c;
			p_n <= p_c;
			x_n <= x;
		end
	end

	// squaring stages, one fraction bit of log2 each
	logic [30:0]       m_q [NSQ];
	logic [FRAC_W-1:0] f_q [NSQ];
	logic [4:0]        p_q [NSQ];
	logic [XW-1:0]     x_q [NSQ];

	genvar s;
	generate
		for (s = 0; s < NSQ; s++) begin : g_sq
			logic [30:0]       m_in;
			logic [FRAC_W-1:0] f_in;
			logic [4:0]        p_in;
			logic [XW-1:0]     x_in;
			logic [61:0]       sq;
			logic [31:0]       t;
			if (s == 0) begin : g_first
				assign m_in = m_n;
				assign f_in = '0;
				assign p_in = p_n;
				assign x_in = x_n;
			end else begin : g_next
				assign m_in = m_q[s-1];
				assign f_in = f_q[s-1];
				assign p_in = p_q[s-1];
				assign x_in = x_q[s-1];
			end
			assign sq = m_in * m_in;
			assign t  = sq[61:30];
			always_ff @(posedge clk) begin
				if (en) begin
					m_q[s] <= t[31] ? t[31:1] : t[30:0];
					f_q[s] <= {f_in[FRAC_W-2:0], t[31]};
					p_q[s] <= p_in;
					x_q[s] <= x_in;
				end
			end
		end
	endgenerate

	// scale by ln2
	logic [UW-1:0] u_c;
	logic [4:0]    k_c;
	logic [PW-1:0] prod_m;
	logic [XW-1:0] x_m;

	assign k_c = 5'(EST_FRAC_BITS) - p_q[NSQ-1];
	assign u_c = {k_c, {FRAC_W{1'b0}}} - {5'b0, f_q[NSQ-1]};

	always_ff @(posedge clk) begin
		if (en) begin
			prod_m <= u_c * LN2_Q24;
			x_m    <= x_q[NSQ-1];
		end
	end

	// round, negate, floor a zero estimate
	logic [PW-1:0] rnd_c;
	logic [LW-1:0] mag_c;

	assign rnd_c = prod_m + (PW'(1) << (55 - LOG_FRAC_BITS));
	assign mag_c = LW'(rnd_c >> (56 - LOG_FRAC_BITS));

	always_ff @(posedge clk) begin
		if (en) begin
			logp  <= (x_m == '0) ? log_floor : $signed(-mag_c);
			x_out <= x_m;
		end
	end
endmodule

// ----- design/dirichlet_transition_estimate.sv -----
// Dirichlet pseudocount transition estimator.
// src carries one source state and three Q16.16 transition frequencies per
// transaction; dst returns three Q1.16 posterior means, their Q8.16 natural
// logs and a status code, one result per input transaction.
// cfg writes the effective counts (index 0..2) and the log floor (index 3);
// cfg is always ready; the user must write it only while the block is idle,
// which the block itself does not enforce. The pipeline runs through the
// front stages, the restoring divider (one quotient bit per stage) and the
// 32 squaring stages of the log unit to the merge. Three lanes run side by
// side, one per destination state. Throughput is one transaction per cycle
// while dst takes results. The whole pipeline advances as one; when dst
// stalls with a result waiting, src ready drops and every stage holds, and
// it resumes without loss when dst takes the result.
// Reset clears the pipeline valid bits and loads the register defaults:
// match count 1.0, insert and delete counts 0, log floor -256.0.
module dirichlet_transition_estimate #(
	parameter int EST_FRAC_BITS     = dte_pkg::EST_FRAC_BITS_DEF,
	parameter int LOG_FRAC_BITS     = dte_pkg::LOG_FRAC_BITS_DEF,
	parameter int SUM_TOLERANCE_LSB = dte_pkg::SUM_TOLERANCE_LSB_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dte_cfg_if.sink       cfg,
	dte_in_if.sink        src,
	dte_out_if.source     dst
);
	import dte_pkg::*;

	localparam int XW      = EST_FRAC_BITS + 1;
	localparam int LW      = LOG_FRAC_BITS + 9;
	localparam int DIV_LAT = EST_FRAC_BITS + 2;
	localparam int LOG_LAT = 35;
	localparam int LAT     = DIV_LAT + LOG_LAT;
	localparam int VL      = LAT + 3;
	localparam int TW      = EST_FRAC_BITS + 3;

	logic adv;
	assign adv       = !dst.valid || dst.ready;
	assign src.ready = adv;
	assign cfg.ready = 1'b1;

	// configuration registers
	logic [COUNT_W-1:0]  eff_q [LANES];
	logic signed [LW-1:0] floor_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eff_q[0] <= 32'd65536;
			eff_q[1] <= '0;
			eff_q[2] <= '0;
			floor_q  <= -LW'(16777216);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_EFF_MATCH:  eff_q[0] <= cfg.data;
				REG_EFF_INSERT: eff_q[1] <= cfg.data;
				REG_EFF_DELETE: eff_q[2] <= cfg.data;
				REG_LOG_FLOOR:  floor_q  <= LW'(cfg.data);
				default: ;
			endcase
		end
	end

	// valid chain
	logic [VL-1:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[VL-2:0], src.valid};
		end
	end
	assign dst.valid = vld_q[VL-1];

	// stage 1: weight frequencies by the state's count
	logic [COUNT_W-1:0] n_c;
	logic [FREQ_W-1:0]  freq_c [LANES];
	logic [NUM_W-1:0]   prod_s1 [LANES];
	logic [ALPHA_W-1:0] alpha_s1 [LANES];
	logic               inv_s1;

	always_comb begin
		unique case (src.source_state)
			SRC_MATCH:  n_c = eff_q[0];
			SRC_INSERT: n_c = eff_q[1];
			SRC_DELETE: n_c = eff_q[2];
			default:    n_c = '0;
		endcase
		freq_c[0] = src.freq_to_match;
		freq_c[1] = src.freq_to_insert;
		freq_c[2] = src.freq_to_delete;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				prod_s1[k]  <= n_c * freq_c[k];
				alpha_s1[k] <= alpha_of(src.source_state, k);
			end
			inv_s1 <= src.source_state == SRC_INVALID;
		end
	end

	// stage 2: numerators and common denominator
	logic [NUM_W-1:0] num_c [LANES];
	logic [DEN_W-1:0] den_c;
	logic [NUM_W-1:0] num_s2 [LANES];
	logic [DEN_W-1:0] den_s2;
	item_flags_t      flg_s2;

	always_comb begin
		den_c = '0;
		for (int k = 0; k < LANES; k++) begin
			num_c[k] = prod_s1[k] + {{(NUM_W-ALPHA_W-16){1'b0}}, alpha_s1[k], 16'b0};
			den_c    = den_c + {2'b0, num_c[k]};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s2          <= num_c;
			den_s2          <= den_c;
			flg_s2.invalid  <= inv_s1;
			flg_s2.zero_den <= den_c == '0;
		end
	end

	// flags travel beside the lanes
	item_flags_t flg_q [LAT];
	always_ff @(posedge clk) begin
		if (adv) begin
			flg_q[0] <= flg_s2;
			for (int i = 1; i < LAT; i++) flg_q[i] <= flg_q[i-1];
		end
	end

	// lanes
	logic [XW-1:0]        est_d [LANES];
	logic [XW-1:0]        est_l [LANES];
	logic signed [LW-1:0] logp_l [LANES];

	genvar g;
	generate
		for (g = 0; g < LANES; g++) begin : g_lane
			dte_div_lane #(.EST_FRAC_BITS(EST_FRAC_BITS)) u_div (
				.clk (clk),
				.en  (adv),
				.num (num_s2[g]),
				.den (den_s2),
				.est (est_d[g])
			);
			dte_log_lane #(
				.EST_FRAC_BITS(EST_FRAC_BITS),
				.LOG_FRAC_BITS(LOG_FRAC_BITS)
			) u_log (
				.clk       (clk),
				.en        (adv),
				.x         (est_d[g]),
				.log_floor (floor_q),
				.x_out     (est_l[g]),
				.logp      (logp_l[g])
			);
		end
	endgenerate

	// merge: sum check and status
	logic [TW-1:0] total_c;
	logic [TW-1:0] diff_c;
	logic [TW-1:0] one_c;
	item_flags_t   flg_c;

	always_comb begin
		flg_c   = flg_q[LAT-1];
		one_c   = TW'(1) << EST_FRAC_BITS;
		total_c = TW'(est_l[0]) + TW'(est_l[1]) + TW'(est_l[2]);
		diff_c  = (total_c > one_c) ? total_c - one_c : one_c - total_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (flg_c.invalid || flg_c.zero_den) begin
				dst.prob_to_match  <= '0;
				dst.prob_to_insert <= '0;
				dst.prob_to_delete <= '0;
				dst.logp_to_match  <= '0;
				dst.logp_to_insert <= '0;
				dst.logp_to_delete <= '0;
				dst.status         <= flg_c.invalid ? STAT_INVALID : STAT_ZERO_DEN;
			end else begin
				dst.prob_to_match  <= est_l[0];
				dst.prob_to_insert <= est_l[1];
				dst.prob_to_delete <= est_l[2];
				dst.logp_to_match  <= logp_l[0];
				dst.logp_to_insert <= logp_l[1];
				dst.logp_to_delete <= logp_l[2];
				dst.status         <= (diff_c > TW'(SUM_TOLERANCE_LSB)) ? STAT_SUM_TOL : STAT_OK;
			end
		end
	end
endmodule
